// ----- src/fbpd_pkg.sv -----
// Package for the FSR baseline pressure detector.
// Shared constants, item kinds, register addresses and the sequencer states.
// No dependencies.
package fbpd_pkg;

    // Default parameter values
    localparam int SLOTS_DEF       = 8;
    localparam int SAMPLE_BITS_DEF = 10;

    // Fixed field widths
    localparam int SLOT_W   = 3;
    localparam int FUNC_W   = 2;
    localparam int NOISE_W  = 10;
    localparam int WINMS_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Register reset values
    localparam logic [NOISE_W-1:0] NOISE_RST = 10'd40;
    localparam logic [WINMS_W-1:0] WINMS_RST = 16'd250;

    // Saturation limits
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [WINMS_W-1:0] ELAPSED_MAX = 16'hFFFF;

    // Item kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_t;

    // Register select (paddr bit 2)
    localparam logic REG_NOISE = 1'b0;
    localparam logic REG_WINMS = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRESS,
        ST_EMIT,
        ST_DIV
    } state_t;

endpackage

// ----- src/fsr_baseline_pressure_detector.sv -----
// FSR baseline pressure detector: per-slot rest baseline, serial pressure
// subtractor and bit-serial window divider. Depends on fbpd_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries func, slot, sample. A sample
//   item gives one result on the output channel (out_valid/out_stall) with
//   out_slot, pressure and calibrating. Tick, clear and unused kinds give no
//   result. Thresholds and window length are set over the APB port
//   (0x0 noise_threshold, 0x4 calibration_window_ms); pready is always high.
// Timing:
//   A sample runs through a one-bit serial subtract/compare unit, one bit
//   per cycle over max(SAMPLE_BITS,10) bits; the result is then loaded into
//   the output register from ST_EMIT, and the sequencer returns to idle
//   and takes the next item only once that load has happened.
//   A tick that closes a window runs a restoring divider, one quotient bit per
//   cycle over SAMPLE_BITS+16 bits; the input stalls until it finishes.
//   Other ticks, clear and unused kinds leave the sequencer idle, ready for the next item.
// Reset clears all calibration, the window and the output valid flag; the
// registers return to 40 and 250. While the receiver stalls, a finished result
// holds in the output register; the block keeps taking ticks and clears, and a
// following sample waits at the end of its serial pass until the register frees.
module fsr_baseline_pressure_detector #(
    parameter int SLOTS       = fbpd_pkg::SLOTS_DEF,
    parameter int SAMPLE_BITS = fbpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [fbpd_pkg::FUNC_W-1:0] func,
    input  logic [fbpd_pkg::SLOT_W-1:0] slot,
    input  logic [SAMPLE_BITS-1:0]      sample,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [fbpd_pkg::SLOT_W-1:0] out_slot,
    output logic [SAMPLE_BITS-1:0]      pressure,
    output logic                        calibrating,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fbpd_pkg::APB_AW-1:0] paddr,
    input  logic [fbpd_pkg::APB_DW-1:0] pwdata,
    output logic [fbpd_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int SUM_W    = SAMPLE_BITS + fbpd_pkg::COUNT_W;
    localparam int CMP_W    = (SAMPLE_BITS > fbpd_pkg::NOISE_W) ? SAMPLE_BITS
                                                                : fbpd_pkg::NOISE_W;
    localparam int CNT_W    = $clog2(SUM_W + 1);
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int COUNT_W  = fbpd_pkg::COUNT_W;
    localparam int WINMS_W  = fbpd_pkg::WINMS_W;
    localparam int NOISE_W  = fbpd_pkg::NOISE_W;
    localparam int SLOT_W   = fbpd_pkg::SLOT_W;

    localparam logic [CNT_W-1:0] PRESS_LAST = CNT_W'(CMP_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(SUM_W - 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [NOISE_W-1:0] noise_reg;
    logic [WINMS_W-1:0] winms_reg;
    logic               cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg <= fbpd_pkg::NOISE_RST;
            winms_reg <= fbpd_pkg::WINMS_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == fbpd_pkg::REG_NOISE)
                noise_reg <= pwdata[NOISE_W-1:0];
            else
                winms_reg <= pwdata[WINMS_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == fbpd_pkg::REG_NOISE)
            prdata = fbpd_pkg::APB_DW'(noise_reg);
        else
            prdata = fbpd_pkg::APB_DW'(winms_reg);
    end

    // ---------------------------------------------------------------
    // Declarations
    // ---------------------------------------------------------------
    fbpd_pkg::state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] base_mem_reg [SLOTS];
    logic [SLOTS-1:0]       cal_flags_reg;

    logic                   win_active_reg;
    logic [SLOT_W-1:0]      win_slot_reg;
    logic [SUM_W-1:0]       win_sum_reg;     // also the dividend/quotient shifter
    logic [COUNT_W-1:0]     win_count_reg;
    logic [WINMS_W-1:0]     win_elapsed_reg;
    logic [COUNT_W-1:0]     rem_reg;

    logic [CNT_W-1:0]       cnt_reg;

    // serial pressure unit
    logic [CMP_W-1:0]       a_reg;           // baseline
    logic [CMP_W-1:0]       b_reg;           // sample
    logic [CMP_W-1:0]       t_reg;           // noise threshold
    logic [CMP_W-1:0]       d_reg;           // difference, shifted in at the MSB, LSB first
    logic                   br1_reg;         // borrow of baseline - sample
    logic                   br2_reg;         // borrow of difference - threshold
    logic                   zero_reg;        // force pressure zero
    logic                   res_cal_reg;
    logic [SLOT_W-1:0]      res_slot_reg;

    // output register
    logic                   out_valid_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [SAMPLE_BITS-1:0] pressure_reg;
    logic                   calibrating_reg;

    logic                   in_acc;
    logic                   out_free;
    logic                   emit_load;
    logic                   press_last;
    logic                   div_last;
    logic                   is_sample;
    logic                   is_tick;
    logic                   is_clear;
    logic                   slot_ok;
    logic [IDX_W-1:0]       in_idx;
    logic [IDX_W-1:0]       win_idx;
    logic                   in_cal;
    logic [WINMS_W-1:0]     elapsed_inc;
    logic                   win_close;
    logic                   div_start;

    // serial bit logic
    logic                   s_diff1;
    logic                   s_br1;
    logic                   s_br2;

    // divider step
    logic [COUNT_W:0]       div_trial;
    logic                   div_ge;
    logic [COUNT_W-1:0]     div_rem;

    // ---------------------------------------------------------------
    // Item decode
    // ---------------------------------------------------------------
    assign in_acc    = in_valid && !in_stall;
    assign is_sample = (func == fbpd_pkg::FUNC_SAMPLE);
    assign is_tick   = (func == fbpd_pkg::FUNC_TICK);
    assign is_clear  = (func == fbpd_pkg::FUNC_CLEAR);
    assign slot_ok   = (32'(slot) < 32'(SLOTS));
    assign in_idx    = IDX_W'(slot);
    assign win_idx   = IDX_W'(win_slot_reg);
    assign in_cal    = slot_ok && cal_flags_reg[in_idx];

    // Tick handling: saturating elapsed count and window close
    assign elapsed_inc = (win_elapsed_reg == fbpd_pkg::ELAPSED_MAX) ? win_elapsed_reg
                                                                   : win_elapsed_reg + 1'b1;
    assign win_close   = win_active_reg && (elapsed_inc >= winms_reg);
    assign div_start   = in_acc && is_tick && win_close;

    assign press_last = (cnt_reg == PRESS_LAST);
    assign div_last   = (cnt_reg == DIV_LAST);
    assign out_free   = !out_valid_reg || !out_stall;

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fbpd_pkg::ST_IDLE:
            begin
                if (in_acc && is_sample)
                    state_next = fbpd_pkg::ST_PRESS;
                else if (div_start)
                    state_next = fbpd_pkg::ST_DIV;
            end
            fbpd_pkg::ST_PRESS:
            begin
                if (press_last)
                    state_next = fbpd_pkg::ST_EMIT;
            end
            fbpd_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = fbpd_pkg::ST_IDLE;
            end
            fbpd_pkg::ST_DIV:
            begin
                if (div_last)
                    state_next = fbpd_pkg::ST_IDLE;
            end
            default: state_next = fbpd_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        in_stall  = 1'b1;
        emit_load = 1'b0;
        unique case (state_reg)
            fbpd_pkg::ST_IDLE:  in_stall = 1'b0;
            fbpd_pkg::ST_PRESS: in_stall = 1'b1;
            fbpd_pkg::ST_EMIT:  emit_load = out_free;
            fbpd_pkg::ST_DIV:   in_stall = 1'b1;
            default:            in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fbpd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------------------------------------------------------
    // Step counter for serial pressure and divider
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (state_reg == fbpd_pkg::ST_IDLE)
            cnt_reg <= '0;
        else if (state_reg == fbpd_pkg::ST_PRESS || state_reg == fbpd_pkg::ST_DIV)
            cnt_reg <= cnt_reg + 1'b1;
    end

    // ---------------------------------------------------------------
    // Divider step: one quotient bit per cycle
    // ---------------------------------------------------------------
    assign div_trial = {rem_reg, win_sum_reg[SUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, win_count_reg});
    always_comb
    begin
        if (div_ge)
            div_rem = COUNT_W'(div_trial - {1'b0, win_count_reg});
        else
            div_rem = div_trial[COUNT_W-1:0];
    end

    // ---------------------------------------------------------------
    // Window state and calibration flags
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_active_reg  <= 1'b0;
            win_slot_reg    <= '0;
            win_sum_reg     <= '0;
            win_count_reg   <= '0;
            win_elapsed_reg <= '0;
            cal_flags_reg   <= '0;
            rem_reg         <= '0;
        end
        else if (state_reg == fbpd_pkg::ST_DIV)
        begin
            if (div_last)
            begin
                cal_flags_reg[win_idx] <= 1'b1;
                win_active_reg         <= 1'b0;
                win_sum_reg            <= '0;
                win_count_reg          <= '0;
                win_elapsed_reg        <= '0;
            end
            else
            begin
                win_sum_reg <= {win_sum_reg[SUM_W-2:0], div_ge};
                rem_reg     <= div_rem;
            end
        end
        else if (in_acc)
        begin
            if (is_clear)
            begin
                cal_flags_reg   <= '0;
                win_active_reg  <= 1'b0;
                win_slot_reg    <= '0;
                win_sum_reg     <= '0;
                win_count_reg   <= '0;
                win_elapsed_reg <= '0;
            end
            else if (is_tick && win_active_reg)
            begin
                win_elapsed_reg <= elapsed_inc;
                rem_reg         <= '0;
            end
            else if (is_sample && slot_ok && !in_cal)
            begin
                if (!win_active_reg)
                begin
                    win_active_reg  <= 1'b1;
                    win_slot_reg    <= slot;
                    win_sum_reg     <= SUM_W'(sample);
                    win_count_reg   <= COUNT_W'(1);
                    win_elapsed_reg <= '0;
                end
                else if (win_slot_reg == slot && win_count_reg != fbpd_pkg::COUNT_MAX)
                begin
                    win_sum_reg   <= win_sum_reg + SUM_W'(sample);
                    win_count_reg <= win_count_reg + 1'b1;
                end
            end
        end
    end

    // Baseline store: written at the end of a division
    always_ff @(posedge clk)
    begin
        if (state_reg == fbpd_pkg::ST_DIV && div_last)
            base_mem_reg[win_idx] <= {win_sum_reg[SAMPLE_BITS-2:0], div_ge};
    end

    // ---------------------------------------------------------------
    // Serial subtract and threshold compare, LSB first
    // ---------------------------------------------------------------
    assign s_diff1 = a_reg[0] ^ b_reg[0] ^ br1_reg;
    assign s_br1   = (!a_reg[0] && b_reg[0]) || (!(a_reg[0] ^ b_reg[0]) && br1_reg);
    assign s_br2   = (!s_diff1 && t_reg[0]) || (!(s_diff1 ^ t_reg[0]) && br2_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == fbpd_pkg::ST_IDLE && in_acc && is_sample)
        begin
            a_reg        <= in_cal ? CMP_W'(base_mem_reg[in_idx]) : '0;
            b_reg        <= CMP_W'(sample);
            t_reg        <= CMP_W'(noise_reg);
            br1_reg      <= 1'b0;
            br2_reg      <= 1'b0;
            zero_reg     <= !in_cal;
            res_cal_reg  <= slot_ok && !in_cal;
            res_slot_reg <= slot;
        end
        else if (state_reg == fbpd_pkg::ST_PRESS)
        begin
            a_reg   <= a_reg >> 1;
            b_reg   <= b_reg >> 1;
            t_reg   <= t_reg >> 1;
            d_reg   <= {s_diff1, d_reg[CMP_W-1:1]};
            br1_reg <= s_br1;
            br2_reg <= s_br2;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_slot_reg    <= res_slot_reg;
            calibrating_reg <= res_cal_reg;
            if (zero_reg || br1_reg || br2_reg)
                pressure_reg <= '0;
            else
                pressure_reg <= d_reg[SAMPLE_BITS-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_slot    = out_slot_reg;
    assign pressure    = pressure_reg;
    assign calibrating = calibrating_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // divisor is never zero while dividing
    a_div_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fbpd_pkg::ST_DIV |-> win_count_reg != '0)
        else $error("divider running with zero count");

    // partial remainder stays below the divisor
    a_div_rem_lt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fbpd_pkg::ST_DIV |-> rem_reg < win_count_reg)
        else $error("divider remainder out of range");

    // a finished division closes the window
    a_div_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fbpd_pkg::ST_DIV && div_last) |=> !win_active_reg)
        else $error("window still open after division");

    // open window always belongs to an existing slot
    a_win_slot_ok: assert property (@(posedge clk) disable iff (!rst_n)
        win_active_reg |-> 32'(win_slot_reg) < 32'(SLOTS))
        else $error("window slot out of range");

    // an uncalibrated result never carries pressure
    a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && calibrating_reg) |-> pressure_reg == '0)
        else $error("pressure reported while calibrating");

endmodule

// ----- dv/fbpd_pressure_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the FSR baseline pressure detector: watches the item channels and
// the APB port, predicts every pressure result and compares. Depends on fbpd_pkg.
module fbpd_pressure_checker #(
    parameter int SLOTS       = fbpd_pkg::SLOTS_DEF,
    parameter int SAMPLE_BITS = fbpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [fbpd_pkg::FUNC_W-1:0] func,
    input  logic [fbpd_pkg::SLOT_W-1:0] slot,
    input  logic [SAMPLE_BITS-1:0]      sample,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [fbpd_pkg::SLOT_W-1:0] out_slot,
    input  logic [SAMPLE_BITS-1:0]      pressure,
    input  logic                        calibrating,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fbpd_pkg::APB_AW-1:0] paddr,
    input  logic [fbpd_pkg::APB_DW-1:0] pwdata,
    input  logic                        pready,
    output int                          fail_count,
    output int                          pending_results,
    output int                          results_checked,
    output int                          windows_closed
);

    localparam int SUM_W = SAMPLE_BITS + fbpd_pkg::COUNT_W;

    typedef struct packed {
        logic [fbpd_pkg::SLOT_W-1:0] slot_id;
        logic [SAMPLE_BITS-1:0]      level;
        logic                        calib;
    } press_result_t;

    press_result_t          expected_q[$];
    press_result_t          got_res;
    press_result_t          want_res;

    // Shadow of the per-slot baselines and the running calibration window
    logic [SAMPLE_BITS-1:0]          rest_level [SLOTS];
    bit                              slot_ready [SLOTS];
    bit                              win_open;
    logic [fbpd_pkg::SLOT_W-1:0]     win_slot;
    logic [SUM_W-1:0]                win_sum;
    logic [fbpd_pkg::COUNT_W-1:0]    win_count;
    logic [fbpd_pkg::WINMS_W-1:0]    win_elapsed;

    // Shadow of the two registers
    logic [fbpd_pkg::NOISE_W-1:0]    noise_cfg;
    logic [fbpd_pkg::WINMS_W-1:0]    window_cfg;

    function automatic void clear_calibration();
        for (int i = 0; i < SLOTS; i++)
        begin
            rest_level[i] = '0;
            slot_ready[i] = 1'b0;
        end
        win_open    = 1'b0;
        win_slot    = '0;
        win_sum     = '0;
        win_count   = '0;
        win_elapsed = '0;
    endfunction

    // Millisecond tick: age the window, close it into a baseline once long enough
    function automatic void advance_ms();
        if (!win_open)
            return;
        if (win_elapsed != fbpd_pkg::ELAPSED_MAX)
            win_elapsed++;
        if (win_elapsed >= window_cfg)
        begin
            if (win_slot < SLOTS && win_count != 0)
            begin
                rest_level[win_slot] = SAMPLE_BITS'(win_sum / win_count);
                slot_ready[win_slot] = 1'b1;
            end
            windows_closed++;
            win_open    = 1'b0;
            win_sum     = '0;
            win_count   = '0;
            win_elapsed = '0;
        end
    endfunction

    // Sample: pressure against the baseline, or feed the calibration window
    function automatic press_result_t predict_sample(input logic [fbpd_pkg::SLOT_W-1:0] s,
                                                     input logic [SAMPLE_BITS-1:0] v);
        press_result_t          r;
        logic [SAMPLE_BITS-1:0] d;
        r.slot_id = s;
        r.level   = '0;
        r.calib   = 1'b0;
        if (s < SLOTS)
        begin
            if (slot_ready[s])
            begin
                if (v < rest_level[s])
                begin
                    d = rest_level[s] - v;
                    if (d >= noise_cfg)
                        r.level = d;
                end
            end
            else
            begin
                r.calib = 1'b1;
                if (!win_open)
                begin
                    win_open    = 1'b1;
                    win_slot    = s;
                    win_sum     = SUM_W'(v);
                    win_count   = fbpd_pkg::COUNT_W'(1);
                    win_elapsed = '0;
                end
                else if (win_slot == s && win_count != fbpd_pkg::COUNT_MAX)
                begin
                    win_sum = win_sum + SUM_W'(v);
                    win_count++;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_calibration();
            noise_cfg  = fbpd_pkg::NOISE_RST;
            window_cfg = fbpd_pkg::WINMS_RST;
            expected_q.delete();
            pending_results = 0;
        end
        else
        begin
            // results leave before the item taken in the same cycle is predicted
            if (out_valid && !out_stall)
            begin
                got_res = '{out_slot, pressure, calibrating};
                results_checked++;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected result: slot %0d pressure %0d calibrating %0d",
                                 $time, out_slot, pressure, calibrating);
                end
                else
                begin
                    want_res = expected_q.pop_front();
                    if (got_res.slot_id !== want_res.slot_id || got_res.level !== want_res.level
                        || got_res.calib !== want_res.calib)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"[%0t] result mismatch: expected slot %0d pressure %0d ",
                                      "calibrating %0d, got slot %0d pressure %0d calibrating %0d"},
                                     $time, want_res.slot_id, want_res.level, want_res.calib,
                                     got_res.slot_id, got_res.level, got_res.calib);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                case (func)
                    fbpd_pkg::FUNC_SAMPLE: expected_q.push_back(predict_sample(slot, sample));
                    fbpd_pkg::FUNC_TICK:   advance_ms();
                    fbpd_pkg::FUNC_CLEAR:  clear_calibration();
                    default:               ;
                endcase
            end

            // register write lands on the access phase
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == fbpd_pkg::REG_WINMS)
                    window_cfg = pwdata[fbpd_pkg::WINMS_W-1:0];
                else
                    noise_cfg = pwdata[fbpd_pkg::NOISE_W-1:0];
            end

            pending_results = expected_q.size();
        end
    end

endmodule

// ----- dv/tb_fsr_baseline_pressure_detector.sv -----
`timescale 1ns / 1ps
// Top of the FSR baseline pressure detector testbench: clock, reset, stimulus and
// verdict. Depends on fbpd_pkg, the detector RTL and fbpd_pressure_checker.
module tb_fsr_baseline_pressure_detector;

    localparam int SB = fbpd_pkg::SAMPLE_BITS_DEF;
    localparam int FW = fbpd_pkg::FUNC_W;
    localparam int SW = fbpd_pkg::SLOT_W;
    localparam int DW = fbpd_pkg::APB_DW;
    localparam logic [FW-1:0] FUNC_UNUSED = 2'd3;
    // divider pass after a closing tick plus slack
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 2000;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic [FW-1:0]               func      = '0;
    logic [SW-1:0]               slot      = '0;
    logic [SB-1:0]               sample    = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [SW-1:0]               out_slot;
    logic [SB-1:0]               pressure;
    logic                        calibrating;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [fbpd_pkg::APB_AW-1:0] paddr     = '0;
    logic [DW-1:0]               pwdata    = '0;
    logic [DW-1:0]               prdata;
    logic                        pready;

    int fail_count;
    int pending_results;
    int results_checked;
    int windows_closed;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int quiet_cycles = 0;
    int n_samples    = 0;
    int n_ticks      = 0;
    int n_clears     = 0;
    int n_unused     = 0;
    int n_settings   = 1;

    fsr_baseline_pressure_detector uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .slot        (slot),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_slot    (out_slot),
        .pressure    (pressure),
        .calibrating (calibrating),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    fbpd_pressure_checker scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .slot            (slot),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_slot        (out_slot),
        .pressure        (pressure),
        .calibrating     (calibrating),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .windows_closed  (windows_closed)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    // Watchdog: too long without any item, result or register access
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                             QUIET_LIMIT, pending_results);
                    $display("fsr_baseline_pressure_detector regression: fail");
                    $finish;
                end
            end
        end
    end

    task automatic set_idling(input int snd_pct, input int rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
    endtask

    // Drive one item, with random sender gaps, and wait until it is taken
    task automatic push_item(input logic [FW-1:0] f, input logic [SW-1:0] s,
                             input logic [SB-1:0] v);
        @(negedge clk);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        slot     <= s;
        sample   <= v;
        case (f)
            fbpd_pkg::FUNC_SAMPLE: n_samples++;
            fbpd_pkg::FUNC_TICK:   n_ticks++;
            fbpd_pkg::FUNC_CLEAR:  n_clears++;
            default:               n_unused++;
        endcase
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stop sending and let every result and any divider pass finish
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic reg_sel, input logic [DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int noise, input int win_ms);
        write_reg(fbpd_pkg::REG_NOISE, DW'(noise));
        write_reg(fbpd_pkg::REG_WINMS, DW'(win_ms));
        n_settings++;
    endtask

    // Random traffic: samples cluster on a focus slot so windows fill and close
    task automatic random_batch(input int n_items, input int tick_pct);
        int            r;
        int            pick;
        logic [SW-1:0] focus;
        logic [SW-1:0] s;
        logic [SB-1:0] v;
        focus = SW'($urandom_range(0, 7));
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 99) < 5)
                focus = SW'($urandom_range(0, 7));
            s = ($urandom_range(0, 99) < 60) ? focus : SW'($urandom_range(0, 7));
            pick = $urandom_range(0, 99);
            if (pick < 10)
                v = $urandom_range(0, 1) ? {SB{1'b1}} : '0;
            else if (pick < 55)
                v = SB'($urandom_range(700, 1023));
            else
                v = SB'($urandom_range(0, 1023));
            r = $urandom_range(0, 99);
            if (r < 2)
                push_item(fbpd_pkg::FUNC_CLEAR, s, v);
            else if (r < 4)
                push_item(FUNC_UNUSED, s, v);
            else if (r < 4 + tick_pct)
                push_item(fbpd_pkg::FUNC_TICK, s, v);
            else
                push_item(fbpd_pkg::FUNC_SAMPLE, s, v);
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Reset registers: 250-tick window, noise floor of 40 right at the edge
        set_idling(23, 46);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd2, 10'd800);
        repeat (249) push_item(fbpd_pkg::FUNC_TICK, 3'd0, 10'd0);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd2, 10'd900);
        push_item(fbpd_pkg::FUNC_TICK, 3'd0, 10'd0);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd2, 10'd811);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd2, 10'd810);
        settle_block();

        // Shortest window, no noise floor
        configure(0, 1);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd0, 10'd1023);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd0, 10'd0);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd1, 10'd512);     // other slot while window busy
        push_item(FUNC_UNUSED, 3'd0, 10'd0);
        push_item(fbpd_pkg::FUNC_TICK, 3'd0, 10'd0);         // closes, baseline 511
        push_item(fbpd_pkg::FUNC_TICK, 3'd0, 10'd0);         // no window open
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd0, 10'd511);     // equal to baseline
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd0, 10'd600);     // above baseline
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd0, 10'd510);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd0, 10'd0);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd7, 10'd1023);
        push_item(fbpd_pkg::FUNC_TICK, 3'd7, 10'd1023);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd7, 10'd0);       // full-scale pressure
        push_item(fbpd_pkg::FUNC_CLEAR, 3'd0, 10'd0);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd7, 10'd0);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd4, 10'd1023);
        push_item(fbpd_pkg::FUNC_CLEAR, 3'd0, 10'd0);        // aborts the open window
        push_item(fbpd_pkg::FUNC_TICK, 3'd0, 10'd0);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd4, 10'd5);
        push_item(fbpd_pkg::FUNC_TICK, 3'd4, 10'd5);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd4, 10'd5);
        settle_block();

        // Top noise floor on a full-scale baseline
        configure(1023, 1);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd3, 10'd1023);
        push_item(fbpd_pkg::FUNC_TICK, 3'd0, 10'd0);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd3, 10'd0);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd3, 10'd1);
        settle_block();

        // Longest window stays open until a clear aborts it
        configure(1023, 65535);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd5, 10'd1000);
        repeat (30) push_item(fbpd_pkg::FUNC_TICK, 3'd0, 10'd0);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd5, 10'd900);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd3, 10'd0);
        push_item(fbpd_pkg::FUNC_CLEAR, 3'd0, 10'd0);
        push_item(fbpd_pkg::FUNC_SAMPLE, 3'd3, 10'd0);
        settle_block();

        // Random segments, one register setting each
        set_idling(23, 46);
        configure($urandom_range(0, 100), $urandom_range(1, 4));
        random_batch(190, 30);
        settle_block();
        configure(0, 1);
        random_batch(190, 25);
        settle_block();

        set_idling(46, 23);
        configure(1023, $urandom_range(1, 8));
        random_batch(190, 30);
        settle_block();
        configure($urandom_range(0, 1023), $urandom_range(1, 20));
        random_batch(190, 40);
        settle_block();

        set_idling(0, 0);
        configure(40, $urandom_range(20, 60));
        random_batch(190, 50);
        settle_block();
        configure($urandom_range(0, 60), $urandom_range(1, 30));
        random_batch(190, 40);
        settle_block();

        $display("covered %0d samples, %0d ticks, %0d clears, %0d unused items over %0d settings",
                 n_samples, n_ticks, n_clears, n_unused, n_settings);
        $display("checked %0d pressure results, %0d calibration windows closed, %0d failures",
                 results_checked, windows_closed, fail_count);
        if (fail_count == 0)
            $display("fsr_baseline_pressure_detector regression: pass");
        else
            $display("fsr_baseline_pressure_detector regression: fail");
        $finish;
    end

endmodule
